@@ sv/tlbf_pkg.sv @@
// tlbf_pkg: shared constants, codes and types for the fifo-replacement tlb
// used by tlbf_ctrl, tlbf_datapath and tlb_fifo_replacement
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlbf_pkg;

    // address width of the ports
    localparam int ADDR_BITS = 32;
    // width of the entry index field on the result channel
    localparam int INDEX_OUT_BITS = 4;
    // defaults handed to the top level parameters
    localparam int DEF_TLB_ENTRIES = 16;
    localparam int DEF_OFFSET_BITS = 10;

    // command codes on the input channel
    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_FILL   = 1'b1
    } tlbf_cmd_t;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } tlbf_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;  // capture the input beat
        logic exec;  // compare or write, and load the result register
    } tlbf_ctrl_t;

endpackage : tlbf_pkg

`default_nettype wire

@@ sv/tlbf_ctrl.sv @@
// tlbf_ctrl: controller state machine of the tlb, drives handshakes and datapath commands
// depends on tlbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlbf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output tlbf_pkg::tlbf_ctrl_t     ctrl
);

    tlbf_pkg::tlbf_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tlbf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        state_next = state_reg;
        s_ready    = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.exec  = 1'b0;
        unique case (state_reg)
            tlbf_pkg::ST_IDLE: begin
                // no beat is taken while reset is held
                s_ready   = aresetn;
                ctrl.load = s_valid && aresetn;
                if (s_valid) begin
                    state_next = tlbf_pkg::ST_BUSY;
                end
            end
            tlbf_pkg::ST_BUSY: begin
                // wait here while the result register is still occupied
                if (out_free) begin
                    ctrl.exec  = 1'b1;
                    state_next = tlbf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlbf_pkg::ST_IDLE;
            end
        endcase

        // result beat held until taken
        m_valid_next = m_valid_reg && !m_ready;
        if (ctrl.exec) begin
            m_valid_next = 1'b1;
        end
    end

    assign m_valid = m_valid_reg;

endmodule : tlbf_ctrl

`default_nettype wire

@@ sv/tlbf_datapath.sv @@
// tlbf_datapath: input capture, entry store with parallel page compare,
// fifo fill pointer and result register; depends on tlbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlbf_datapath #(
    parameter int TLB_ENTRIES = tlbf_pkg::DEF_TLB_ENTRIES,
    parameter int OFFSET_BITS = tlbf_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire tlbf_pkg::tlbf_ctrl_t                   ctrl,
    input  wire logic                                   s_cmd,
    input  wire logic [tlbf_pkg::ADDR_BITS-1:0]         s_virt_addr,
    input  wire logic [tlbf_pkg::ADDR_BITS-1:0]         s_phys_addr_in,
    output logic                                        m_hit,
    output logic [tlbf_pkg::ADDR_BITS-1:0]              m_phys_addr_out,
    output logic [tlbf_pkg::INDEX_OUT_BITS-1:0]         m_entry_index
);

    localparam int PAGE_W = tlbf_pkg::ADDR_BITS - OFFSET_BITS;
    localparam int IDX_W  = $clog2(TLB_ENTRIES);
    localparam int OUT_W  = tlbf_pkg::INDEX_OUT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    // captured input beat
    logic                              cmd_reg;
    logic [tlbf_pkg::ADDR_BITS-1:0]    va_reg;
    logic [PAGE_W-1:0]                 pa_page_reg;

    // entry store
    logic [TLB_ENTRIES-1:0]            valid_reg, valid_next;
    logic [PAGE_W-1:0]                 page_reg  [TLB_ENTRIES];
    logic [PAGE_W-1:0]                 frame_reg [TLB_ENTRIES];
    logic [IDX_W-1:0]                  ptr_reg, ptr_next;

    // result register
    logic                              hit_reg, hit_next;
    logic [tlbf_pkg::ADDR_BITS-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;

    logic [PAGE_W-1:0]                 va_page;
    logic [TLB_ENTRIES-1:0]            match;
    logic                              any_hit;
    logic [IDX_W-1:0]                  hit_idx;
    logic [PAGE_W-1:0]                 hit_frame;
    logic                              do_fill;
    logic [IDX_W+OUT_W-1:0]            idx_ext;

    // input capture
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            cmd_reg     <= s_cmd;
            va_reg      <= s_virt_addr;
            pa_page_reg <= s_phys_addr_in[tlbf_pkg::ADDR_BITS-1:OFFSET_BITS];
        end
    end

    assign va_page = va_reg[tlbf_pkg::ADDR_BITS-1:OFFSET_BITS];
    assign do_fill = ctrl.exec && (cmd_reg == tlbf_pkg::CMD_FILL);

    // parallel page compare, one comparator per entry
    always_comb begin
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (page_reg[i] == va_page);
        end
    end

    // lowest matching entry wins
    always_comb begin
        any_hit   = 1'b0;
        hit_idx   = '0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                any_hit   = 1'b1;
                hit_idx   = IDX_W'(i);
                hit_frame = frame_reg[i];
            end
        end
    end

    // result beat and fifo pointer
    always_comb begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (cmd_reg == tlbf_pkg::CMD_FILL) begin
            hit_next  = 1'b0;
            addr_next = '0;
            idx_next  = ptr_reg;
        end else begin
            hit_next  = any_hit;
            addr_next = any_hit ? {hit_frame, va_reg[OFFSET_BITS-1:0]} : '0;
            idx_next  = any_hit ? hit_idx : '0;
        end
        // valid entries always form a prefix, so the pointer is also the first free entry
        if (do_fill) begin
            valid_next[ptr_reg] = 1'b1;
            ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
        end
    end

    // control state of the store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    // entry payload writes
    always_ff @(posedge aclk) begin
        if (do_fill) begin
            page_reg[ptr_reg]  <= va_page;
            frame_reg[ptr_reg] <= pa_page_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
            idx_reg  <= idx_next;
        end
    end

    assign idx_ext         = {{OUT_W{1'b0}}, idx_reg};
    assign m_hit           = hit_reg;
    assign m_phys_addr_out = addr_reg;
    assign m_entry_index   = idx_ext[OUT_W-1:0];

endmodule : tlbf_datapath

`default_nettype wire

@@ sv/tlb_fifo_replacement.sv @@
// tlb_fifo_replacement: fully associative tlb with fifo replacement, top level
// Channels: s_* input beat (s_cmd lookup or fill, s_virt_addr, s_phys_addr_in),
//   m_* result beat (m_hit, m_phys_addr_out, m_entry_index), both valid/ready.
// A lookup compares the page number of s_virt_addr against every entry at once;
//   the lowest matching valid entry gives the frame, joined with the page offset.
//   A miss returns hit low, address zero and index zero.
// A fill writes the entry under the fill pointer (the first free one, or the
//   oldest once all are full) and returns its index with hit low and address zero.
// Beats go one at a time: each is captured, then passes the compare-and-write stage,
//   which handles a single beat at a time; the next beat is taken only after it.
// The result is offered from the result register, which is loaded in the
//   compare-and-write stage from the captured beat.
// A new beat is taken while the previous result waits in the output register;
//   if the receiver stalls, that beat waits in the compare stage and s_ready
//   stays low until the output register is free.
// Reset (aresetn, synchronous, active low) clears all valid bits, the fill
//   pointer and both handshakes; no clearing pass is needed.
// Depends on tlbf_pkg, tlbf_ctrl and tlbf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module tlb_fifo_replacement #(
    parameter int TLB_ENTRIES = tlbf_pkg::DEF_TLB_ENTRIES,
    parameter int OFFSET_BITS = tlbf_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_cmd,
    input  wire logic [tlbf_pkg::ADDR_BITS-1:0]      s_virt_addr,
    input  wire logic [tlbf_pkg::ADDR_BITS-1:0]      s_phys_addr_in,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_hit,
    output logic [tlbf_pkg::ADDR_BITS-1:0]           m_phys_addr_out,
    output logic [tlbf_pkg::INDEX_OUT_BITS-1:0]      m_entry_index
);

    tlbf_pkg::tlbf_ctrl_t ctrl;

    // controller
    tlbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    // datapath
    tlbf_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .s_cmd           (s_cmd),
        .s_virt_addr     (s_virt_addr),
        .s_phys_addr_in  (s_phys_addr_in),
        .m_hit           (m_hit),
        .m_phys_addr_out (m_phys_addr_out),
        .m_entry_index   (m_entry_index)
    );

`ifndef SYNTHESIS
    // an accepted beat blocks the input for the next cycle
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat was still in work");

    // the compare stage never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec |-> (!m_valid || m_ready))
        else $error("result register overwritten before it was taken");

    // every executed beat is offered on the next cycle
    a_exec_offers: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.exec |=> m_valid)
        else $error("executed beat not offered on the result channel");

    // a miss or a fill carries a zero address
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_phys_addr_out == '0))
        else $error("nonzero address without a hit");
`endif

endmodule : tlb_fifo_replacement

`default_nettype wire

@@ dv/tb_tlb_fifo_replacement.sv @@
// tb_tlb_fifo_replacement: self-checking testbench for the fifo-replacement tlb
// directed and random lookup/fill beats against a local model of the entry table
// depends on tlbf_pkg and tlb_fifo_replacement
`timescale 1ns / 1ps

module tb_tlb_fifo_replacement;

    localparam int N_ENTRIES    = tlbf_pkg::DEF_TLB_ENTRIES;
    localparam int OFF_BITS     = tlbf_pkg::DEF_OFFSET_BITS;
    localparam int ADDR_W       = tlbf_pkg::ADDR_BITS;
    localparam int IDX_W        = tlbf_pkg::INDEX_OUT_BITS;
    localparam int PAGE_BITS    = ADDR_W - OFF_BITS;
    localparam int MAX_GAP      = 6;
    localparam int RAND_CHUNKS  = 17;
    localparam int CHUNK_BEATS  = 50;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic             hit;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  index;
    } tlb_result_t;

    // clock, reset and block ports
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_cmd = tlbf_pkg::CMD_LOOKUP;
    logic [ADDR_W-1:0] s_virt_addr = '0;
    logic [ADDR_W-1:0] s_phys_addr_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit;
    logic [ADDR_W-1:0] m_phys_addr_out;
    logic [IDX_W-1:0]  m_entry_index;

    // local copy of the entry table
    logic                 tlb_valid [N_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_page  [N_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame [N_ENTRIES];
    int                   fill_ptr;

    tlb_result_t          pending_translations[$];
    tlb_result_t          oldest;
    logic [PAGE_BITS-1:0] filled_pages[$];

    bit no_idle = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;
    int lookup_count = 0;
    int hit_count = 0;
    int fill_count = 0;
    int beats_checked = 0;

    tlb_fifo_replacement #(
        .TLB_ENTRIES (N_ENTRIES),
        .OFFSET_BITS (OFF_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_virt_addr     (s_virt_addr),
        .s_phys_addr_in  (s_phys_addr_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_phys_addr_out (m_phys_addr_out),
        .m_entry_index   (m_entry_index)
    );

    // 10 ns clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // model one accepted beat and queue its translation result
    task automatic predict_translation(input tlbf_pkg::tlbf_cmd_t cmd,
                                       input logic [ADDR_W-1:0] va,
                                       input logic [ADDR_W-1:0] pa);
        tlb_result_t          res;
        logic [PAGE_BITS-1:0] vpn;
        int                   victim;
        bit                   found;
        res.hit   = 1'b0;
        res.addr  = '0;
        res.index = '0;
        vpn       = va[ADDR_W-1:OFF_BITS];
        found     = 1'b0;
        if (cmd == tlbf_pkg::CMD_LOOKUP) begin
            // lowest-index valid match wins
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!found && tlb_valid[i] && tlb_page[i] == vpn) begin
                    found     = 1'b1;
                    res.hit   = 1'b1;
                    res.addr  = {tlb_frame[i], va[OFF_BITS-1:0]};
                    res.index = IDX_W'(i);
                end
            end
            lookup_count++;
            if (found) hit_count++;
        end else begin
            // first free entry, otherwise the oldest one under the pointer
            victim = fill_ptr;
            for (int i = N_ENTRIES - 1; i >= 0; i--) begin
                if (!tlb_valid[i]) victim = i;
            end
            tlb_valid[victim] = 1'b1;
            tlb_page[victim]  = vpn;
            tlb_frame[victim] = pa[ADDR_W-1:OFF_BITS];
            fill_ptr          = (victim + 1) % N_ENTRIES;
            res.index         = IDX_W'(victim);
            fill_count++;
        end
        pending_translations.push_back(res);
    endtask

    // drive one input beat, holding it until accepted
    task automatic send_beat(input tlbf_pkg::tlbf_cmd_t cmd, input logic [ADDR_W-1:0] va,
                             input logic [ADDR_W-1:0] pa);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_virt_addr    <= va;
        s_phys_addr_in <= pa;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_translation(cmd, va, pa);
        if (cmd == tlbf_pkg::CMD_FILL) begin
            filled_pages.push_back(va[ADDR_W-1:OFF_BITS]);
            if (filled_pages.size() > 2 * N_ENTRIES) void'(filled_pages.pop_front());
        end
    endtask

    // result side back-pressure, drawn per beat
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // compare each result beat with the oldest pending translation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_translations.size() == 0) begin
                $error("result beat with nothing pending: hit %0b addr %08h index %0d",
                       m_hit, m_phys_addr_out, m_entry_index);
                fail_count++;
            end else begin
                oldest = pending_translations.pop_front();
                beats_checked++;
                if (m_hit !== oldest.hit) begin
                    $error("m_hit: expected %0b, got %0b", oldest.hit, m_hit);
                    fail_count++;
                end
                if (m_phys_addr_out !== oldest.addr) begin
                    $error("m_phys_addr_out: expected %08h, got %08h",
                           oldest.addr, m_phys_addr_out);
                    fail_count++;
                end
                if (m_entry_index !== oldest.index) begin
                    $error("m_entry_index: expected %0d, got %0d",
                           oldest.index, m_entry_index);
                    fail_count++;
                end
            end
        end
    end

    // lookups into an empty table must all miss
    task automatic test_empty_lookup();
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // fills and lookups at the address extremes, offset extremes included
    task automatic test_fill_extremes();
        send_beat(tlbf_pkg::CMD_FILL,   32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(tlbf_pkg::CMD_FILL,   32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'h0000_03FF, 32'h0000_0000);
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'hFFFF_FC00, 32'hFFFF_FFFF);
    endtask

    // a second entry for a resident page, lookup must pick the lower index
    task automatic test_duplicate_fill();
        send_beat(tlbf_pkg::CMD_FILL,   32'h0000_0155, 32'hA5A5_A5A5);
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'h0000_02AA, 32'h5A5A_5A5A);
    endtask

    // fill to capacity, then one more to overwrite the oldest entry
    task automatic test_wrap_replacement();
        for (int k = 1; k <= N_ENTRIES - 2; k++) begin
            send_beat(tlbf_pkg::CMD_FILL, 32'(k) << 12, 32'($urandom));
        end
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'h0000_0123, 32'h0);
        send_beat(tlbf_pkg::CMD_LOOKUP, 32'h0000_E3C5, 32'h0);
    endtask

    // lookups mostly to recently filled pages, fills of known, extreme or fresh pages, some wild addresses
    task automatic test_random_traffic();
        logic [ADDR_W-1:0]    va;
        logic [ADDR_W-1:0]    pa;
        logic [PAGE_BITS-1:0] vpn;
        int                   pick;
        for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (CHUNK_BEATS) begin
                pa   = $urandom;
                va   = $urandom;
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 40) begin
                    // fill: refill a known page, an extreme page or a fresh one
                    if (pick < 25 && filled_pages.size() > 0) begin
                        vpn = filled_pages[$urandom_range(0, filled_pages.size() - 1)];
                        va  = {vpn, va[OFF_BITS-1:0]};
                    end else if (pick < 35) begin
                        va = {{PAGE_BITS{pick[0]}}, va[OFF_BITS-1:0]};
                    end
                    send_beat(tlbf_pkg::CMD_FILL, va, pa);
                end else begin
                    // lookup: a recently filled page with any offset, else anything
                    if (pick < 70 && filled_pages.size() > 0) begin
                        vpn = filled_pages[$urandom_range(0, filled_pages.size() - 1)];
                        va  = {vpn, va[OFF_BITS-1:0]};
                    end
                    send_beat(tlbf_pkg::CMD_LOOKUP, va, pa);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // sequence of tests
    initial begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            tlb_valid[i] = 1'b0;
            tlb_page[i]  = '0;
            tlb_frame[i] = '0;
        end
        fill_ptr = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_empty_lookup();
        test_fill_extremes();
        test_duplicate_fill();
        test_wrap_replacement();
        test_random_traffic();

        // drain outstanding results, then let the pipeline settle
        s_valid <= 1'b0;
        while (pending_translations.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d lookups (%0d hits) and %0d fills, with fifo wrap",
                 lookup_count, hit_count, fill_count);
        $display("%0d result beats checked under random gaps and back-pressure",
                 beats_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule : tb_tlb_fifo_replacement
